// ===== sv/fate_pkg.sv =====
// Shared types, constants and helper functions for the FAT table entry engine.
// Used by the interfaces, the top level and the testbench; depends on nothing else.

package fate_pkg;

    // Table store size in bytes, split into an even-byte and an odd-byte bank
    localparam int TABLE_BYTES = 8192;
    localparam int BANK_DEPTH  = TABLE_BYTES / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    localparam int CL_W    = 16;   // cluster numbers and entries
    localparam int OFF_W   = 18;   // byte offset of an entry (3n/2 for 16-bit n)
    localparam int DATA_W  = 32;   // configuration data bus
    localparam int PADDR_W = 3;    // two registers at byte addresses 0 and 4

    typedef logic [CL_W-1:0]    cluster_t;
    typedef logic [OFF_W-1:0]   offset_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_ALLOC = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        REG_TWELVE = 1'b0,
        REG_COUNT  = 1'b1
    } reg_idx_t;

    localparam cluster_t   FIRST_CLUSTER = 16'd2;
    localparam cluster_t   COUNT_RESET   = 16'd4096;
    localparam cluster_t   CHAIN_END_MIN = 16'hfff8;
    localparam logic [11:0] FAT12_END_MIN = 12'hff8;
    localparam cluster_t   FAT12_SIGN    = 16'hf000;
    localparam cluster_t   ALLOC_MARK    = 16'hffff;

    // Byte offset of an entry: 3n/2 for FAT12, 2n for FAT16
    function automatic offset_t entry_offset(input cluster_t n, input logic twelve);
        offset_t k;
        if (twelve)
            k = OFF_W'(n) + OFF_W'(n >> 1);
        else
            k = {1'b0, n, 1'b0};
        return k;
    endfunction

    // Step a cluster number upward, wrapping to the first data cluster
    function automatic cluster_t next_cluster(input cluster_t n, input cluster_t cnt);
        logic [CL_W:0] inc;
        inc = {1'b0, n} + (CL_W+1)'(1);
        if (inc >= {1'b0, cnt})
            return FIRST_CLUSTER;
        return inc[CL_W-1:0];
    endfunction

    // Unpack an entry from its byte pair {hi, lo}
    function automatic cluster_t decode_entry(input cluster_t raw, input logic twelve,
                                              input logic odd);
        logic [11:0] v12;
        v12 = odd ? raw[15:4] : raw[11:0];
        if (!twelve)
            return raw;
        if (v12 >= FAT12_END_MIN)
            return FAT12_SIGN | {4'h0, v12};
        return {4'h0, v12};
    endfunction

    // Merge a new entry value into its byte pair {hi, lo}
    function automatic cluster_t merge_entry(input cluster_t raw, input cluster_t val,
                                             input logic twelve, input logic odd);
        cluster_t res;
        if (twelve && odd)
            res = {val[11:4], val[3:0], raw[3:0]};
        else if (twelve)
            res = {raw[15:12], val[11:8], val[7:0]};
        else
            res = val;
        return res;
    endfunction

endpackage

// ===== sv/fate_if.sv =====
// Request and response channel interfaces of the FAT table entry engine.
// Depends on fate_pkg for field widths.

interface fate_req_if;
    import fate_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    cluster_t    cluster;
    cluster_t    value;

    modport source (output valid, mode, cluster, value, input ready);
    modport sink   (input valid, mode, cluster, value, output ready);
endinterface

interface fate_rsp_if;
    import fate_pkg::*;

    logic        valid;
    logic        ready;
    cluster_t    entry;
    logic        chain_end;
    logic [1:0]  status;

    modport source (output valid, entry, chain_end, status, input ready);
    modport sink   (input valid, entry, chain_end, status, output ready);
endinterface

// ===== sv/fat_table_entry_engine_top.sv =====
// Top level of the FAT table entry engine: byte banks, sequencer, APB registers.
// Depends on fate_pkg and the channel interfaces in fate_if.sv.
//
// Usage: a request word on req (mode, cluster, value) reads an entry, writes
// an entry, or allocates a free cluster; each request yields one response
// word on rsp (entry, chain_end, status). twelve_bit_mode and cluster_count
// are to be set over the APB port while no request is in flight; the block
// does not enforce this.
// A read or write issues its bank read on acceptance, checks the byte pair
// and writes back, then loads the output register. An allocate examines at
// most cluster_count - 2 clusters, or one when there are no data clusters;
// one candidate is checked per cycle, the next one's read issued meanwhile.
// One request is in flight at a time; a write-back always completes before
// the next request issues its read, so no forwarding path is needed.
// Stalls: the response waits in an output register; the next request is
// accepted meanwhile and its result is held until that register empties.
// Reset: clears the sequencer, sets the free pointer to 2 and the registers
// to FAT16 with 4096 clusters; the table bytes are undefined until written.

module fat_table_entry_engine_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fate_pkg::PADDR_W-1:0]   paddr,
    input  logic [fate_pkg::DATA_W-1:0]    pwdata,
    output logic [fate_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    fate_req_if.sink                       req,
    fate_rsp_if.source                     rsp
);
    import fate_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    // Byte banks: even byte offsets and odd byte offsets
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] even_q;
    logic [7:0] odd_q;

    // Configuration registers
    logic       twelve_reg;
    cluster_t   count_reg;

    // Sequencer state
    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    cluster_t   value_reg, value_next;
    cluster_t   start_reg, start_next;
    cluster_t   issue_reg, issue_next;
    cluster_t   rover_reg, rover_next;

    // Access stage: the candidate whose bytes arrive from the banks
    cluster_t   acc_cluster_reg;
    logic       acc_off_ok_reg;
    logic       acc_in_range_reg;
    logic       acc_k_odd_reg;
    bank_addr_t acc_even_addr_reg;
    bank_addr_t acc_odd_addr_reg;

    // Pending result and output register
    cluster_t   res_entry_reg, res_entry_next;
    logic       res_chain_reg, res_chain_next;
    logic [1:0] res_status_reg, res_status_next;
    cluster_t   out_entry_reg;
    logic       out_chain_reg;
    logic [1:0] out_status_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;

    // Datapath signals
    logic       accept;
    logic       scanning;
    logic       rd_en;
    cluster_t   scan_start;
    cluster_t   cand;
    offset_t    cand_k;
    offset_t    cand_k1;
    cluster_t   raw;
    cluster_t   ent;
    cluster_t   wval;
    cluster_t   merged;
    logic       rd_ok;
    logic       is_free;
    logic       we;
    logic [7:0] wr_even_data;
    logic [7:0] wr_odd_data;

    // APB register file; pready is always high
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twelve_reg <= 1'b0;
            count_reg  <= COUNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_TWELVE: twelve_reg <= pwdata[0];
                REG_COUNT:  count_reg  <= pwdata[CL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TWELVE: prdata = DATA_W'(twelve_reg);
            REG_COUNT:  prdata = DATA_W'(count_reg);
            default:    prdata = '0;
        endcase
    end

    // Handshake and read issue
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign scanning  = (state_reg == ST_CHECK) && (op_reg == MODE_ALLOC);
    assign rd_en     = accept || scanning;

    assign scan_start = (rover_reg < FIRST_CLUSTER || rover_reg >= count_reg) ?
                        FIRST_CLUSTER : rover_reg;
    assign cand = (state_reg == ST_CHECK) ? issue_reg :
                  ((req.mode == MODE_ALLOC) ? scan_start : req.cluster);
    assign cand_k  = entry_offset(cand, twelve_reg);
    assign cand_k1 = cand_k + OFF_W'(1);

    // Banks: registered read, write-back from the access stage
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            even_q <= even_mem[cand_k1[BANK_AW:1]];
            odd_q  <= odd_mem[cand_k[BANK_AW:1]];
        end
        if (we)
        begin
            even_mem[acc_even_addr_reg] <= wr_even_data;
            odd_mem[acc_odd_addr_reg]   <= wr_odd_data;
        end
    end

    // Capture the candidate alongside its bank read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            acc_cluster_reg   <= cand;
            acc_off_ok_reg    <= (cand_k < OFF_W'(TABLE_BYTES - 1));
            acc_in_range_reg  <= (cand >= FIRST_CLUSTER) && (cand < count_reg);
            acc_k_odd_reg     <= cand_k[0];
            acc_even_addr_reg <= cand_k1[BANK_AW:1];
            acc_odd_addr_reg  <= cand_k[BANK_AW:1];
        end
    end

    // Unpack the byte pair and build the merged write-back
    assign raw     = acc_k_odd_reg ? {even_q, odd_q} : {odd_q, even_q};
    assign ent     = decode_entry(raw, twelve_reg, acc_cluster_reg[0]);
    assign wval    = (op_reg == MODE_ALLOC) ? ALLOC_MARK : value_reg;
    assign merged  = merge_entry(raw, wval, twelve_reg, acc_cluster_reg[0]);
    assign rd_ok   = acc_in_range_reg && acc_off_ok_reg;
    assign is_free = rd_ok && (ent == '0);

    assign wr_even_data = acc_k_odd_reg ? merged[15:8] : merged[7:0];
    assign wr_odd_data  = acc_k_odd_reg ? merged[7:0]  : merged[15:8];
    assign we = (state_reg == ST_CHECK) &&
                (((op_reg == MODE_WRITE) && acc_off_ok_reg) ||
                 ((op_reg == MODE_ALLOC) && is_free));

    // Move a finished result into the output register once it is free
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        start_next      = start_reg;
        issue_next      = issue_reg;
        rover_next      = rover_reg;
        res_entry_next  = res_entry_reg;
        res_chain_next  = res_chain_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.mode;
                    value_next = req.value;
                    start_next = scan_start;
                    issue_next = next_cluster(scan_start, count_reg);
                    case (req.mode) inside
                        MODE_READ, MODE_WRITE, MODE_ALLOC:
                            state_next = ST_CHECK;
                        default:
                        begin
                            // unused code: no effect, all-zero result
                            res_entry_next  = '0;
                            res_chain_next  = 1'b0;
                            res_status_next = STAT_OK;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                res_entry_next  = '0;
                res_chain_next  = 1'b0;
                res_status_next = STAT_OK;
                case (op_reg)
                    MODE_READ:
                    begin
                        res_entry_next  = rd_ok ? ent : '0;
                        res_chain_next  = rd_ok && (ent >= CHAIN_END_MIN);
                        res_status_next = rd_ok ? STAT_OK : STAT_RANGE;
                        state_next      = ST_DONE;
                    end
                    MODE_WRITE:
                    begin
                        res_status_next = acc_off_ok_reg ? STAT_OK : STAT_RANGE;
                        state_next      = ST_DONE;
                    end
                    MODE_ALLOC:
                    begin
                        // next candidate already in flight; advance the issue pointer
                        issue_next = next_cluster(issue_reg, count_reg);
                        if (is_free)
                        begin
                            res_entry_next = acc_cluster_reg;
                            rover_next     = issue_reg;
                            state_next     = ST_DONE;
                        end
                        else if (issue_reg == start_reg)
                        begin
                            res_status_next = STAT_FULL;
                            state_next      = ST_DONE;
                        end
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end

            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rover_reg     <= FIRST_CLUSTER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        start_reg      <= start_next;
        issue_reg      <= issue_next;
        res_entry_reg  <= res_entry_next;
        res_chain_reg  <= res_chain_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_entry_reg  <= res_entry_reg;
            out_chain_reg  <= res_chain_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.entry     = out_entry_reg;
    assign rsp.chain_end = out_chain_reg;
    assign rsp.status    = out_status_reg;

`ifndef ASSERT_OFF
    // Write-back happens only in the check state
    a_we_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == ST_CHECK)
        else $error("table write outside check state");

    // A write-back ends the request
    a_we_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> state_reg == ST_DONE)
        else $error("table write not followed by result");

    // The issue pointer runs one cluster ahead of the checked candidate
    a_scan_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        scanning |-> issue_reg == next_cluster(acc_cluster_reg, count_reg))
        else $error("scan pointers out of step");

    // The free pointer never drops below the first data cluster
    a_rover_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rover_reg >= FIRST_CLUSTER)
        else $error("free pointer below first cluster");

    // A new response appears only from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside done state");
`endif

endmodule

// ===== verif/fate_response_check.sv =====
// Response checker for the FAT table entry engine: predicts every response word
// from the request words and register writes it sees, and compares in order.
// Depends on fate_pkg and the channel interfaces in fate_if.sv.
`timescale 1ns / 1ps

module fate_response_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fate_pkg::PADDR_W-1:0]   paddr,
    input  logic [fate_pkg::DATA_W-1:0]    pwdata,
    input  logic [fate_pkg::DATA_W-1:0]    prdata,
    input  logic                           pready,
    fate_req_if                            req,
    fate_rsp_if                            rsp,
    output int                             fail_count,
    output int                             pending
);
    import fate_pkg::*;

    typedef struct packed {
        cluster_t entry;
        logic     chain_end;
        status_t  status;
    } answer_t;

    // Predicted response words, oldest first
    answer_t    answers [$];

    // Shadow of the table store, the free pointer and the registers
    logic [7:0] fat_bytes [TABLE_BYTES];
    logic       twelve;
    cluster_t   count;
    int         rover;

    // Byte offset of an entry; false when its byte pair runs past the store
    function automatic bit pair_at(input int n, output int k);
        k = twelve ? (3 * n) / 2 : 2 * n;
        return (k + 1 < TABLE_BYTES);
    endfunction

    function automatic bit fetch_entry(input int n, output cluster_t v);
        int          k;
        logic [15:0] raw;
        logic [11:0] v12;
        v = '0;
        if (n < FIRST_CLUSTER || n >= count)
            return 1'b0;
        if (!pair_at(n, k))
            return 1'b0;
        raw = {fat_bytes[k + 1], fat_bytes[k]};
        if (!twelve)
            v = raw;
        else
        begin
            // odd clusters sit in the upper twelve bits of the pair
            v12 = n[0] ? raw[15:4] : raw[11:0];
            v = (v12 >= FAT12_END_MIN) ? (FAT12_SIGN | {4'h0, v12}) : {4'h0, v12};
        end
        return 1'b1;
    endfunction

    function automatic bit store_entry(input int n, input cluster_t val);
        int k;
        if (!pair_at(n, k))
            return 1'b0;
        if (twelve && n[0])
        begin
            fat_bytes[k]     = {val[3:0], fat_bytes[k][3:0]};
            fat_bytes[k + 1] = val[11:4];
        end
        else if (twelve)
        begin
            fat_bytes[k]     = val[7:0];
            fat_bytes[k + 1] = {fat_bytes[k + 1][7:4], val[11:8]};
        end
        else
        begin
            fat_bytes[k]     = val[7:0];
            fat_bytes[k + 1] = val[15:8];
        end
        return 1'b1;
    endfunction

    // Work out the response to one request and advance the shadow state
    function automatic answer_t serve_request(input logic [1:0] mode, input cluster_t cl,
                                              input cluster_t val);
        answer_t  a;
        cluster_t v;
        int       start;
        int       n;
        bit       found;
        a = '0;
        case (mode)
            MODE_READ:
            begin
                if (fetch_entry(int'(cl), v))
                begin
                    a.entry     = v;
                    a.chain_end = (v >= CHAIN_END_MIN);
                end
                else
                    a.status = STAT_RANGE;
            end
            MODE_WRITE:
            begin
                if (!store_entry(int'(cl), val))
                    a.status = STAT_RANGE;
            end
            MODE_ALLOC:
            begin
                // scan upward from the free pointer, wrap to the first data cluster
                start = rover;
                if (start < FIRST_CLUSTER || start >= count)
                    start = FIRST_CLUSTER;
                n     = start;
                found = 1'b0;
                do
                begin
                    if (fetch_entry(n, v) && v == '0)
                        found = 1'b1;
                    else
                    begin
                        n++;
                        if (n >= count)
                            n = FIRST_CLUSTER;
                    end
                end
                while (!found && n != start);
                if (found)
                begin
                    rover = n + 1;
                    if (rover >= count)
                        rover = FIRST_CLUSTER;
                    void'(store_entry(n, ALLOC_MARK));
                    a.entry = n[CL_W-1:0];
                end
                else
                    a.status = STAT_FULL;
            end
            default:
            begin
                // unused mode: nothing changes, all fields stay zero
            end
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t  want;
        reg_idx_t which;
        if (!rst_n)
        begin
            answers.delete();
            twelve     = 1'b0;
            count      = COUNT_RESET;
            rover      = FIRST_CLUSTER;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // compare a response word with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (answers.size() == 0)
                begin
                    $display("%0t: response word with nothing expected: entry %h chain_end %b status %0d",
                             $time, rsp.entry, rsp.chain_end, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = answers.pop_front();
                    if (rsp.entry !== want.entry)
                    begin
                        $display("%0t: entry expected %h, got %h", $time, want.entry, rsp.entry);
                        fail_count++;
                    end
                    if (rsp.chain_end !== want.chain_end)
                    begin
                        $display("%0t: chain_end expected %b, got %b",
                                 $time, want.chain_end, rsp.chain_end);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        fail_count++;
                    end
                end
            end

            // predict the answer to each request word taken
            if (req.valid && req.ready)
                answers.push_back(serve_request(req.mode, req.cluster, req.value));

            // follow register writes, check read-back
            if (psel && penable && pready)
            begin
                which = reg_idx_t'(paddr[2]);
                if (pwrite)
                begin
                    if (which == REG_TWELVE)
                        twelve = pwdata[0];
                    else
                        count = pwdata[CL_W-1:0];
                end
                else if (which == REG_TWELVE && prdata[0] !== twelve)
                begin
                    $display("%0t: twelve_bit_mode read expected %b, got %b",
                             $time, twelve, prdata[0]);
                    fail_count++;
                end
                else if (which == REG_COUNT && prdata[CL_W-1:0] !== count)
                begin
                    $display("%0t: cluster_count read expected %h, got %h",
                             $time, count, prdata[CL_W-1:0]);
                    fail_count++;
                end
            end

            pending = answers.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the FAT table entry engine: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on fate_pkg, fate_if.sv, the engine top and fate_response_check.
`timescale 1ns / 1ps

module tb;
    import fate_pkg::*;

    localparam int         RANDOM_ITEMS = 600;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    // last clusters whose byte pair still fits in the store
    localparam int         FAT16_REACH  = TABLE_BYTES / 2 - 1;
    localparam int         FAT12_REACH  = (2 * TABLE_BYTES - 3) / 3;
    // low part of the store loaded up front; in-range reads stay inside it
    localparam int         LOAD_BYTES   = 256;
    localparam int         LOAD16_TOP   = LOAD_BYTES / 2 - 1;
    localparam int         LOAD12_TOP   = (2 * LOAD_BYTES - 3) / 3;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  cycles;
    bit                  calm;
    bit                  hold_rsp;

    fate_req_if req_ch ();
    fate_rsp_if rsp_ch ();

    fat_table_entry_engine_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    fate_response_check resp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Response side: ready with random stall bursts, and one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
                rsp_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Offer one request word, maybe after a gap, and hold it until taken
    task automatic issue_request(input logic [1:0] m, input int cl, input int val);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= m;
        req_ch.cluster <= cl[15:0];
        req_ch.value   <= val[15:0];
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Write a register, then read it back in the next transfer
    task automatic set_register(input reg_idx_t r, input int unsigned d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int tw, input int cnt);
        settle();
        set_register(REG_TWELVE, tw);
        set_register(REG_COUNT, cnt);
    endtask

    initial
    begin : stimulus
        int         c;
        int         i;
        int         n_items;
        int         total;
        int         phase;
        int         sel;
        int         tw;
        int         cnt;
        int         top;
        int         live;
        int         reach;
        int         r;
        int         cl;
        int         val;
        logic [1:0] m;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = MODE_READ;
        req_ch.cluster = '0;
        req_ch.value   = '0;
        calm           = 1'b0;
        hold_rsp       = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Load the low part of the store through FAT16 writes, mostly free entries
        for (c = 0; c < LOAD_BYTES / 2; c++)
            issue_request(MODE_WRITE, c, (c % 4 == 3) ? $urandom_range(0, 16'hffff) : 0);

        // FAT16 at the reset count: range edges, chain ends, writes past the store
        issue_request(MODE_READ, 0, 0);
        issue_request(MODE_READ, 1, 0);
        issue_request(MODE_READ, COUNT_RESET, 0);
        issue_request(MODE_WRITE, FAT16_REACH, 16'hffff);
        issue_request(MODE_READ, FAT16_REACH, 0);
        issue_request(MODE_WRITE, 2, 16'hfff8);
        issue_request(MODE_READ, 2, 0);
        issue_request(MODE_WRITE, 3, 16'hfff7);
        issue_request(MODE_READ, 3, 0);
        issue_request(MODE_WRITE, FAT16_REACH + 1, 16'h1234);
        issue_request(MODE_WRITE, 16'hffff, 16'h5a5a);
        issue_request(MODE_SPARE, 16'hffff, 16'hffff);
        issue_request(MODE_ALLOC, 0, 0);

        // FAT12: odd and even packing, sign extension, upper value bits ignored
        configure(1, COUNT_RESET);
        issue_request(MODE_WRITE, 3, 16'h0ff8);
        issue_request(MODE_READ, 3, 0);
        issue_request(MODE_WRITE, 2, 16'hf7ab);
        issue_request(MODE_READ, 2, 0);
        issue_request(MODE_READ, 3, 0);
        issue_request(MODE_WRITE, FAT12_REACH + 1, 0);
        issue_request(MODE_WRITE, FAT12_REACH, 16'h0ff7);

        // Largest count: byte offset runs out before the cluster range does
        configure(1, 16'hffff);
        issue_request(MODE_READ, FAT12_REACH, 0);
        issue_request(MODE_READ, FAT12_REACH + 1, 0);
        issue_request(MODE_READ, 16'hffff, 0);
        configure(0, 16'hffff);
        issue_request(MODE_READ, FAT16_REACH + 1, 0);

        // Smallest count: no data clusters, so the table is full
        configure(0, 2);
        issue_request(MODE_ALLOC, 0, 0);
        issue_request(MODE_READ, 2, 0);

        // Random phases, each under its own register setting
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS)
        begin
            tw    = $urandom_range(0, 1);
            live  = tw ? LOAD12_TOP : LOAD16_TOP;
            reach = tw ? FAT12_REACH : FAT16_REACH;
            sel   = $urandom_range(0, 9);
            if (sel == 0)
                cnt = 16'hffff;
            else if (sel == 1)
                cnt = 2;
            else if (sel == 2)
                cnt = $urandom_range(3, 6);
            else if (sel == 3)
                cnt = $urandom_range(live - 3, live + 1);
            else if (sel <= 6)
                cnt = $urandom_range(3, 40);
            else
                cnt = $urandom_range(41, live + 1);
            configure(tw, cnt);

            // no idling in the last part of the run
            if (total >= RANDOM_ITEMS * 4 / 5)
                calm = 1'b1;
            // hold the response side off so requests back up behind it
            if (phase == 1)
                hold_rsp = 1'b1;

            top = (cnt - 1 < live) ? cnt - 1 : live;

            n_items = $urandom_range(20, 60);
            for (i = 0; i < n_items; i++)
            begin
                // allocate only where every data cluster lies in the loaded part
                r = $urandom_range(0, 99);
                if (r < 2)
                    m = MODE_SPARE;
                else if (r < 22 && cnt - 1 <= live)
                    m = MODE_ALLOC;
                else if (r < 60)
                    m = MODE_WRITE;
                else
                    m = MODE_READ;

                // aim mostly at live entries, sometimes at the edges and beyond
                if (top >= 2 && $urandom_range(0, 9) < 8)
                    cl = $urandom_range(2, top);
                else
                begin
                    case ($urandom_range(0, 4))
                        0: cl = $urandom_range(0, 1);
                        1: cl = cnt - 1;
                        2: cl = cnt;
                        3: cl = reach + 1;
                        default: cl = $urandom_range(reach + 1, 16'hffff);
                    endcase
                end

                // free entries, FAT12 and FAT16 end markers, or anything
                r = $urandom_range(0, 99);
                if (r < 30)
                    val = 0;
                else if (r < 45)
                    val = ($urandom_range(0, 15) << 12) | $urandom_range(12'hff8, 12'hfff);
                else if (r < 60)
                    val = $urandom_range(16'hfff0, 16'hffff);
                else
                    val = $urandom_range(0, 16'hffff);

                issue_request(m, cl, val);
                total++;
            end
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
